// ===== rtl/core/ssrp_pkg.sv =====
// Shared constants, codes and types for the servo slew ramp / PWM duty block.
// Used by ssrp_duty and servo_slew_ramp_pwm_top; no dependencies.
package ssrp_pkg;

    localparam int OP_W       = 2;
    localparam int ANGLE_W    = 18;
    localparam int GOAL_W     = 16;
    localparam int STEP_W     = 10;
    localparam int RATE_W     = 20;
    localparam int DUTY_W     = 16;
    localparam int OFFSET_W   = 17;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 17;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    localparam int FIFO_DEPTH = 8;

    localparam logic signed [ANGLE_W-1:0] ANGLE_LOW  = -18'sd46080;
    localparam logic signed [ANGLE_W-1:0] ANGLE_HIGH = 18'sd92160;
    localparam logic signed [ANGLE_W-1:0] FULL_SCALE = 18'sd46080;
    localparam logic signed [ANGLE_W:0]   DEADBAND   = 19'sd256;
    localparam logic [STEP_W-1:0]         STEP_MAX   = 10'd1023;

    // Step = floor(rate / TICK_RATE_HZ) by reciprocal multiply, exact for 20-bit rates.
    localparam int TICK_RATE_HZ = 1000;
    localparam int STEP_SHIFT   = RATE_W + $clog2(TICK_RATE_HZ);
    localparam int STEP_MUL_W   = RATE_W + 1;
    localparam int STEP_PROD_W  = RATE_W + STEP_MUL_W;
    localparam longint unsigned STEP_MUL =
        ((64'd1 << STEP_SHIFT) + 64'(TICK_RATE_HZ) - 64'd1) / 64'(TICK_RATE_HZ);

    // Full scale 46080 = 45 << 10; divide by 45 via reciprocal on 22-bit values.
    localparam int DUTY_DIV     = 45;
    localparam int DUTY_DIV_SH  = 10;
    localparam int DUTY_T_W     = 38;
    localparam int DUTY_PROD_W  = 37;
    localparam int DUTY_BASE_W  = 22;
    localparam int TQ_W         = 22;
    localparam int DIV_SHIFT    = 28;
    localparam int DIV_MUL_W    = 23;
    localparam int DIV_PROD_W   = TQ_W + DIV_MUL_W;
    localparam longint unsigned DIV_MUL =
        ((64'd1 << DIV_SHIFT) + 64'(DUTY_DIV) - 64'd1) / 64'(DUTY_DIV);
    localparam logic signed [DUTY_T_W-1:0] CLIP_LIMIT = 38'sd3019898880;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_SET   = 2'd1,
        OP_PLACE = 2'd2
    } t_opcode;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_OFFSET   = 2'd0,
        REG_INVERT   = 2'd1,
        REG_DUTY_MIN = 2'd2,
        REG_DUTY_MAX = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic signed [OFFSET_W-1:0] offset;
        logic                       invert;
        logic [DUTY_W-1:0]          duty_min;
        logic [DUTY_W-1:0]          duty_max;
    } t_duty_cfg;

    typedef struct packed {
        logic                      valid;
        logic signed [ANGLE_W-1:0] angle;
        logic                      moving;
    } t_snap;

    // Packed to match m_axis_tdata from bit 0 upward: duty, angle, active, clipped.
    typedef struct packed {
        logic                      clipped;
        logic                      active;
        logic signed [ANGLE_W-1:0] angle;
        logic [DUTY_W-1:0]         duty;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage

// ===== rtl/core/servo_slew_ramp_pwm_top.sv =====
// Top level of the slew-limited servo positioner with PWM duty mapping.
// Depends on ssrp_pkg, ssrp_duty and ssrp_fifo.
//
// Takes one command per clock while s_axis_tready is high (tick, set target,
// place) and returns one result per command: PWM compare value, present angle,
// ramp status and clip flag. Sustained rate is one item per cycle while
// m_axis_tready stays high. Each result passes the input register, ramp update,
// two duty stages and the result FIFO before m_axis_tvalid rises. s_axis_tready
// drops only when eight items are outstanding, set by the depth of the result
// FIFO. Config writes are taken any cycle; the user must make them only between
// items, as the block itself does not enforce this.
module servo_slew_ramp_pwm_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [17:0] target_angle, [37:18] degrees_per_second, [39:38] zero
    input  logic [ssrp_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [1:0] opcode
    input  logic [ssrp_pkg::OP_W-1:0]           s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [15:0] duty_value, [33:16] present_angle, [34] ramp_active,
    // [35] duty_clipped, [39:36] zero
    output logic [ssrp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [ssrp_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [ssrp_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int CREDIT_W = $clog2(ssrp_pkg::FIFO_DEPTH + 1);

    logic                                r_credit_ok;
    logic [CREDIT_W-1:0]                 r_credit;
    logic                                in_xfer;
    logic                                out_xfer;

    ssrp_pkg::t_duty_cfg                 r_cfg;

    logic                                r_a_valid;
    logic [ssrp_pkg::OP_W-1:0]           r_a_op;
    logic signed [ssrp_pkg::ANGLE_W-1:0] r_a_tgt;
    logic [ssrp_pkg::RATE_W-1:0]         r_a_rate;

    logic signed [ssrp_pkg::ANGLE_W-1:0] r_cur,    n_cur;
    logic [ssrp_pkg::GOAL_W-1:0]         r_goal,   n_goal;
    logic [ssrp_pkg::STEP_W-1:0]         r_step,   n_step;
    logic                                r_moving, n_moving;
    logic                                r_skip,   n_skip;

    ssrp_pkg::t_snap                     r_snap;

    logic signed [ssrp_pkg::ANGLE_W:0]   cur_x;
    logic signed [ssrp_pkg::ANGLE_W:0]   goal_x;
    logic signed [ssrp_pkg::ANGLE_W:0]   diff;
    logic signed [ssrp_pkg::ANGLE_W:0]   moved;
    logic signed [ssrp_pkg::ANGLE_W-1:0] moved_sat;
    logic signed [ssrp_pkg::ANGLE_W-1:0] place_sat;
    logic [ssrp_pkg::GOAL_W-1:0]         goal_clamp;
    logic                                near;
    logic                                at_goal;
    logic [ssrp_pkg::STEP_PROD_W-1:0]    rate_prod;
    logic [ssrp_pkg::STEP_PROD_W-1:0]    step_q;
    logic [ssrp_pkg::STEP_W-1:0]         step_sat;

    logic                                res_valid;
    ssrp_pkg::t_result                   res;
    logic [ssrp_pkg::RESULT_W-1:0]       fifo_data;

    assign s_axis_tready = r_credit_ok;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_xfer      = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit    <= '0;
            r_credit_ok <= 1'b1;
        end else begin
            case ({in_xfer, out_xfer})
                2'b10: begin
                    r_credit    <= r_credit + CREDIT_W'(1);
                    r_credit_ok <= (r_credit + CREDIT_W'(1)) < CREDIT_W'(ssrp_pkg::FIFO_DEPTH);
                end
                2'b01: begin
                    r_credit    <= r_credit - CREDIT_W'(1);
                    r_credit_ok <= 1'b1;
                end
                default: begin
                    r_credit    <= r_credit;
                    r_credit_ok <= r_credit_ok;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset   <= '0;
            r_cfg.invert   <= 1'b0;
            r_cfg.duty_min <= '0;
            r_cfg.duty_max <= '1;
        end else if (i_cfg_we) begin
            case (ssrp_pkg::t_cfg_reg'(i_cfg_addr))
                ssrp_pkg::REG_OFFSET:   r_cfg.offset   <= $signed(i_cfg_wdata);
                ssrp_pkg::REG_INVERT:   r_cfg.invert   <= i_cfg_wdata[0];
                ssrp_pkg::REG_DUTY_MIN: r_cfg.duty_min <= i_cfg_wdata[ssrp_pkg::DUTY_W-1:0];
                ssrp_pkg::REG_DUTY_MAX: r_cfg.duty_max <= i_cfg_wdata[ssrp_pkg::DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= in_xfer;
        end
        r_a_op   <= s_axis_tuser;
        r_a_tgt  <= $signed(s_axis_tdata[ssrp_pkg::ANGLE_W-1:0]);
        r_a_rate <= s_axis_tdata[ssrp_pkg::ANGLE_W+ssrp_pkg::RATE_W-1:ssrp_pkg::ANGLE_W];
    end

    always_comb begin
        cur_x   = (ssrp_pkg::ANGLE_W+1)'(r_cur);
        goal_x  = $signed({3'b000, r_goal});
        diff    = cur_x - goal_x;
        near    = (diff <= ssrp_pkg::DEADBAND) && (diff >= -ssrp_pkg::DEADBAND);
        at_goal = (cur_x == goal_x);

        if (goal_x < cur_x) begin
            moved = cur_x - $signed({9'b0, r_step});
        end else begin
            moved = cur_x + $signed({9'b0, r_step});
        end
        if (moved < (ssrp_pkg::ANGLE_W+1)'(ssrp_pkg::ANGLE_LOW)) begin
            moved_sat = ssrp_pkg::ANGLE_LOW;
        end else if (moved > (ssrp_pkg::ANGLE_W+1)'(ssrp_pkg::ANGLE_HIGH)) begin
            moved_sat = ssrp_pkg::ANGLE_HIGH;
        end else begin
            moved_sat = moved[ssrp_pkg::ANGLE_W-1:0];
        end

        if (r_a_tgt < ssrp_pkg::ANGLE_LOW) begin
            place_sat = ssrp_pkg::ANGLE_LOW;
        end else if (r_a_tgt > ssrp_pkg::ANGLE_HIGH) begin
            place_sat = ssrp_pkg::ANGLE_HIGH;
        end else begin
            place_sat = r_a_tgt;
        end

        if (r_a_tgt[ssrp_pkg::ANGLE_W-1]) begin
            goal_clamp = '0;
        end else if (r_a_tgt > ssrp_pkg::FULL_SCALE) begin
            goal_clamp = ssrp_pkg::FULL_SCALE[ssrp_pkg::GOAL_W-1:0];
        end else begin
            goal_clamp = r_a_tgt[ssrp_pkg::GOAL_W-1:0];
        end

        rate_prod = ssrp_pkg::STEP_PROD_W'(r_a_rate)
                  * ssrp_pkg::STEP_PROD_W'(ssrp_pkg::STEP_MUL);
        step_q    = rate_prod >> ssrp_pkg::STEP_SHIFT;
        step_sat  = (step_q > ssrp_pkg::STEP_PROD_W'(ssrp_pkg::STEP_MAX))
                  ? ssrp_pkg::STEP_MAX : step_q[ssrp_pkg::STEP_W-1:0];

        n_cur    = r_cur;
        n_goal   = r_goal;
        n_step   = r_step;
        n_moving = r_moving;
        n_skip   = r_skip;
        if (r_a_valid) begin
            case (ssrp_pkg::t_opcode'(r_a_op))
                ssrp_pkg::OP_TICK: begin
                    if (r_moving) begin
                        if (r_skip) begin
                            n_skip = 1'b0;
                            if (!at_goal) begin
                                n_cur = moved_sat;
                            end
                        end else if (near) begin
                            n_moving = 1'b0;
                        end else begin
                            n_cur = moved_sat;
                        end
                    end
                end
                ssrp_pkg::OP_SET: begin
                    n_goal = goal_clamp;
                    n_step = step_sat;
                    if (!r_moving) begin
                        n_moving = 1'b1;
                        n_skip   = 1'b1;
                    end
                end
                ssrp_pkg::OP_PLACE: begin
                    n_cur = place_sat;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur        <= '0;
            r_goal       <= '0;
            r_step       <= '0;
            r_moving     <= 1'b0;
            r_skip       <= 1'b0;
            r_snap.valid <= 1'b0;
        end else begin
            r_cur        <= n_cur;
            r_goal       <= n_goal;
            r_step       <= n_step;
            r_moving     <= n_moving;
            r_skip       <= n_skip;
            r_snap.valid <= r_a_valid;
        end
        r_snap.angle  <= n_cur;
        r_snap.moving <= n_moving;
    end

    ssrp_duty u_duty (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_snap   (r_snap),
        .i_cfg    (r_cfg),
        .o_valid  (res_valid),
        .o_result (res)
    );

    ssrp_fifo #(
        .WIDTH (ssrp_pkg::RESULT_W),
        .DEPTH (ssrp_pkg::FIFO_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (res_valid),
        .i_wr_data (res),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (fifo_data)
    );

    assign m_axis_tdata = {{(ssrp_pkg::OUT_DATA_W-ssrp_pkg::RESULT_W){1'b0}}, fifo_data};

`ifndef NO_ASSERTIONS
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= CREDIT_W'(ssrp_pkg::FIFO_DEPTH))
        else $error("outstanding transfer count above FIFO depth");

    a_ready_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit_ok == (r_credit < CREDIT_W'(ssrp_pkg::FIFO_DEPTH)))
        else $error("ready flag out of step with credit count");

    a_skip_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip |-> r_moving)
        else $error("deadband skip pending while ramp idle");

    a_goal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_goal <= ssrp_pkg::FULL_SCALE[ssrp_pkg::GOAL_W-1:0])
        else $error("goal angle beyond full scale");

    a_step_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_a_valid && (r_a_op == ssrp_pkg::OP_SET)) |=> $stable(r_step))
        else $error("step size changed without set target");
`endif

endmodule

// ===== rtl/core/ssrp_duty.sv =====
// Registered duty mapping: angle -> PWM compare value with saturation.
// Depends on ssrp_pkg.
module ssrp_duty (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ssrp_pkg::t_snap       i_snap,
    input  ssrp_pkg::t_duty_cfg   i_cfg,
    output logic                  o_valid,
    output ssrp_pkg::t_result     o_result
);

    localparam int AW = ssrp_pkg::ANGLE_W + 2;
    localparam int SW = ssrp_pkg::DUTY_W + 1;

    logic signed [AW-1:0]                      a_raw;
    logic signed [AW-1:0]                      a_map;
    logic signed [SW-1:0]                      span;
    logic signed [ssrp_pkg::DUTY_T_W-1:0]      t_sum;
    logic [ssrp_pkg::DIV_PROD_W-1:0]           q_prod;
    logic [ssrp_pkg::DIV_PROD_W-ssrp_pkg::DIV_SHIFT-1:0] q_val;

    logic                                      r_c_valid;
    logic signed [ssrp_pkg::DUTY_PROD_W-1:0]   r_c_prod;
    logic [ssrp_pkg::DUTY_BASE_W-1:0]          r_c_base;
    logic signed [ssrp_pkg::ANGLE_W-1:0]       r_c_angle;
    logic                                      r_c_moving;

    logic                                      r_d_valid;
    logic                                      r_d_low;
    logic                                      r_d_high;
    logic [ssrp_pkg::TQ_W-1:0]                 r_d_tq;
    logic signed [ssrp_pkg::ANGLE_W-1:0]       r_d_angle;
    logic                                      r_d_moving;

    always_comb begin
        a_raw = AW'(i_snap.angle) - AW'(i_cfg.offset);
        a_map = i_cfg.invert ? (AW'(ssrp_pkg::FULL_SCALE) - a_raw) : a_raw;
        span  = $signed({1'b0, i_cfg.duty_max}) - $signed({1'b0, i_cfg.duty_min});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= i_snap.valid;
        end
        r_c_prod   <= ssrp_pkg::DUTY_PROD_W'(a_map) * ssrp_pkg::DUTY_PROD_W'(span);
        r_c_base   <= ssrp_pkg::DUTY_BASE_W'(i_cfg.duty_min)
                    * ssrp_pkg::DUTY_BASE_W'(ssrp_pkg::DUTY_DIV);
        r_c_angle  <= i_snap.angle;
        r_c_moving <= i_snap.moving;
    end

    assign t_sum = ssrp_pkg::DUTY_T_W'(r_c_prod)
                 + $signed({6'b0, r_c_base, {ssrp_pkg::DUTY_DIV_SH{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else begin
            r_d_valid <= r_c_valid;
        end
        r_d_low    <= t_sum[ssrp_pkg::DUTY_T_W-1];
        r_d_high   <= !t_sum[ssrp_pkg::DUTY_T_W-1] && (t_sum >= ssrp_pkg::CLIP_LIMIT);
        r_d_tq     <= t_sum[ssrp_pkg::DUTY_DIV_SH+ssrp_pkg::TQ_W-1:ssrp_pkg::DUTY_DIV_SH];
        r_d_angle  <= r_c_angle;
        r_d_moving <= r_c_moving;
    end

    always_comb begin
        q_prod = ssrp_pkg::DIV_PROD_W'(r_d_tq) * ssrp_pkg::DIV_PROD_W'(ssrp_pkg::DIV_MUL);
        q_val  = q_prod[ssrp_pkg::DIV_PROD_W-1:ssrp_pkg::DIV_SHIFT];
        o_valid          = r_d_valid;
        o_result.angle   = r_d_angle;
        o_result.active  = r_d_moving;
        o_result.clipped = r_d_low || r_d_high;
        if (r_d_low) begin
            o_result.duty = '0;
        end else if (r_d_high) begin
            o_result.duty = '1;
        end else begin
            o_result.duty = q_val[ssrp_pkg::DUTY_W-1:0];
        end
    end

endmodule

// ===== rtl/core/ssrp_fifo.sv =====
// Small register-based result FIFO feeding the output stream.
// Generic width and depth (power of two); no package dependency.
module ssrp_fifo #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             rd_en;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign rd_en   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr_en) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            case ({i_wr_en, rd_en})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== tb/servo_result_checker.sv =====
// Result checker for servo_slew_ramp_pwm_top: watches the command, result and
// register-write ports, predicts each result and compares it. Depends on ssrp_pkg.
module servo_result_checker
    import ssrp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_tvalid,
    input  logic                  i_cmd_tready,
    input  logic [IN_DATA_W-1:0]  i_cmd_tdata,
    input  logic [OP_W-1:0]       i_cmd_tuser,
    input  logic                  i_res_tvalid,
    input  logic                  i_res_tready,
    input  logic [OUT_DATA_W-1:0] i_res_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                    o_mismatches,
    output int                    o_outstanding,
    output int                    o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // servo position and ramp state
    logic signed [ANGLE_W-1:0]  angle_now;
    logic [GOAL_W-1:0]          angle_goal;
    logic [STEP_W-1:0]          slew_step;
    logic                       ramping;
    logic                       first_tick;

    // duty mapping setup
    logic signed [OFFSET_W-1:0] mount_offset;
    logic                       mirrored;
    logic [DUTY_W-1:0]          duty_lo;
    logic [DUTY_W-1:0]          duty_hi;

    t_result pending_results[$];

    function automatic logic signed [ANGLE_W-1:0] clamp_angle(input longint v);
        if (v < -46080) return -18'sd46080;
        if (v > 92160) return 18'sd92160;
        return v[ANGLE_W-1:0];
    endfunction

    function automatic void nudge_toward_goal();
        longint c;
        longint g;
        c = angle_now;
        g = angle_goal;
        if (c == g) return;
        if (g < c) c = c - longint'(slew_step);
        else c = c + longint'(slew_step);
        angle_now = clamp_angle(c);
    endfunction

    function automatic t_result step_servo(input logic [OP_W-1:0] op,
                                           input logic signed [ANGLE_W-1:0] tgt,
                                           input logic [RATE_W-1:0] rate);
        longint gap_abs;
        longint a;
        longint span;
        longint t;
        longint q;
        longint s;
        longint g;
        t_result r;
        case (op)
            OP_TICK: begin
                if (ramping) begin
                    if (first_tick) begin
                        first_tick = 1'b0;
                        nudge_toward_goal();
                    end else begin
                        gap_abs = longint'(angle_now) - longint'(angle_goal);
                        if (gap_abs < 0) gap_abs = -gap_abs;
                        if (gap_abs <= 256) ramping = 1'b0;
                        else nudge_toward_goal();
                    end
                end
            end
            OP_SET: begin
                g = tgt;
                if (g < 0) g = 0;
                if (g > 46080) g = 46080;
                angle_goal = g[GOAL_W-1:0];
                s = longint'(rate) / 1000;
                slew_step = (s > 1023) ? 10'd1023 : s[STEP_W-1:0];
                if (!ramping) begin
                    ramping = 1'b1;
                    first_tick = 1'b1;
                end
            end
            OP_PLACE: angle_now = clamp_angle(longint'(tgt));
            default: ;
        endcase

        a = longint'(angle_now) - longint'(mount_offset);
        if (mirrored) a = 46080 - a;
        span = longint'(duty_hi) - longint'(duty_lo);
        t = longint'(duty_lo) * 46080 + a * span;
        if (t < 0) begin
            r.duty = '0;
            r.clipped = 1'b1;
        end else begin
            q = t / 46080;
            r.duty = (q > 65535) ? 16'hFFFF : q[DUTY_W-1:0];
            r.clipped = (q > 65535);
        end
        r.angle = angle_now;
        r.active = ramping;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            angle_now    = '0;
            angle_goal   = '0;
            slew_step    = '0;
            ramping      = 1'b0;
            first_tick   = 1'b0;
            mount_offset = '0;
            mirrored     = 1'b0;
            duty_lo      = '0;
            duty_hi      = 16'hFFFF;
            pending_results.delete();
            o_mismatches  <= 0;
            o_outstanding <= 0;
            o_checked     <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_OFFSET:   mount_offset = i_cfg_wdata[OFFSET_W-1:0];
                    REG_INVERT:   mirrored = i_cfg_wdata[0];
                    REG_DUTY_MIN: duty_lo = i_cfg_wdata[DUTY_W-1:0];
                    REG_DUTY_MAX: duty_hi = i_cfg_wdata[DUTY_W-1:0];
                    default: ;
                endcase
            end
            if (i_res_tvalid && i_res_tready) begin
                got = i_res_tdata[RESULT_W-1:0];
                if (pending_results.size() == 0) begin
                    if (o_mismatches < 10)
                        $display("%0t: result with nothing outstanding: duty=%0d angle=%0d",
                                 $realtime, got.duty, got.angle);
                    o_mismatches <= o_mismatches + 1;
                end else begin
                    want = pending_results.pop_front();
                    if (got.duty !== want.duty || got.angle !== want.angle ||
                        got.active !== want.active || got.clipped !== want.clipped) begin
                        if (o_mismatches < 10)
                            $display({"%0t: mismatch: expected duty=%0d angle=%0d active=%0b ",
                                      "clip=%0b, got duty=%0d angle=%0d active=%0b clip=%0b"},
                                     $realtime, want.duty, want.angle, want.active,
                                     want.clipped, got.duty, got.angle, got.active,
                                     got.clipped);
                        o_mismatches <= o_mismatches + 1;
                    end
                    o_checked <= o_checked + 1;
                end
            end
            if (i_cmd_tvalid && i_cmd_tready)
                pending_results.push_back(step_servo(i_cmd_tuser,
                    i_cmd_tdata[ANGLE_W-1:0], i_cmd_tdata[ANGLE_W+RATE_W-1:ANGLE_W]));
            o_outstanding <= pending_results.size();
        end
    end

endmodule

// ===== tb/servo_slew_ramp_pwm_top_tb.sv =====
// Testbench top for servo_slew_ramp_pwm_top: drives commands and register writes
// under random back-pressure and gives the verdict. Depends on ssrp_pkg, the RTL
// and servo_result_checker.
module servo_slew_ramp_pwm_top_tb;
    import ssrp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // [17:0] target_angle, [37:18] degrees_per_second
    logic [OP_W-1:0]       s_axis_tuser;   // [1:0] opcode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [15:0] duty_value, [33:16] present_angle, [34] ramp_active, [35] duty_clipped
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    int  mismatches;
    int  outstanding;
    int  checked;
    int  cmds_sent;
    int  settings_applied;
    bit  sender_calm;
    bit  receiver_calm;

    servo_slew_ramp_pwm_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    servo_result_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_tvalid  (s_axis_tvalid),
        .i_cmd_tready  (s_axis_tready),
        .i_cmd_tdata   (s_axis_tdata),
        .i_cmd_tuser   (s_axis_tuser),
        .i_res_tvalid  (m_axis_tvalid),
        .i_res_tready  (m_axis_tready),
        .i_res_tdata   (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_axis_tready <= receiver_calm || ($urandom_range(99) >= 20);
    end

    initial begin
        #2ms;
        $display("Timed out with %0d results outstanding", outstanding);
        $display("FAIL servo_slew_ramp_pwm_top");
        $finish;
    end

    task automatic send_cmd(input logic [OP_W-1:0] op, input longint tgt, input longint rate);
        while (!sender_calm && $urandom_range(99) < 20) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, rate[RATE_W-1:0], tgt[ANGLE_W-1:0]};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        cmds_sent++;
    endtask

    // wait for the result stream to drain, then load all four registers
    task automatic load_duty_setting(input longint offs, input bit inv,
                                     input longint dmin, input longint dmax);
        s_axis_tvalid <= 1'b0;
        wait (outstanding == 0);
        repeat (8) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= REG_OFFSET;
        i_cfg_wdata <= offs[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_addr  <= REG_INVERT;
        i_cfg_wdata <= CFG_DATA_W'(inv);
        @(negedge i_clk);
        i_cfg_addr  <= REG_DUTY_MIN;
        i_cfg_wdata <= CFG_DATA_W'(dmin[DUTY_W-1:0]);
        @(negedge i_clk);
        i_cfg_addr  <= REG_DUTY_MAX;
        i_cfg_wdata <= CFG_DATA_W'(dmax[DUTY_W-1:0]);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        settings_applied++;
    endtask

    function automatic longint pick_angle();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 80) return longint'($urandom_range(46080));
        if (r < 90) return longint'($urandom_range(138240)) - 46080;
        return longint'($urandom_range(262143));
    endfunction

    function automatic longint pick_rate();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60)
            return longint'($urandom_range(1023, 300)) * 1000 + longint'($urandom_range(999));
        if (r < 85)
            return longint'($urandom_range(300)) * 1000 + longint'($urandom_range(999));
        return longint'($urandom_range(1048575));
    endfunction

    // mostly set-target followed by a run of ticks, plus places and raw noise
    task automatic run_random(input int count, input int hold_mark);
        int stop_at;
        int hold_at;
        bit held;
        int unsigned r;
        int unsigned k;
        stop_at = cmds_sent + count;
        hold_at = cmds_sent + hold_mark;
        held = (hold_mark <= 0);
        while (cmds_sent < stop_at) begin
            if (!held && cmds_sent >= hold_at) begin
                s_axis_tvalid <= 1'b0;
                wait (outstanding == 0);
                @(negedge i_clk);
                held = 1'b1;
            end
            r = $urandom_range(99);
            if (r < 55) begin
                send_cmd(OP_SET, pick_angle(), pick_rate());
                repeat ($urandom_range(60, 1)) begin
                    k = $urandom_range(99);
                    if (k < 4)
                        send_cmd(OP_PLACE, pick_angle(), longint'($urandom_range(1048575)));
                    else if (k < 7)
                        send_cmd(OP_SET, pick_angle(), pick_rate());
                    else
                        send_cmd(OP_TICK, longint'($urandom_range(262143)),
                                 longint'($urandom_range(1048575)));
                end
            end else if (r < 70) begin
                send_cmd(OP_PLACE, pick_angle(), longint'($urandom_range(1048575)));
            end else if (r < 85) begin
                repeat ($urandom_range(20, 1))
                    send_cmd(OP_TICK, longint'($urandom_range(262143)),
                             longint'($urandom_range(1048575)));
            end else begin
                send_cmd(OP_W'($urandom_range(3)), longint'($urandom_range(262143)),
                         longint'($urandom_range(1048575)));
            end
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        s_axis_tuser     = OP_TICK;
        m_axis_tready    = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_addr       = REG_OFFSET;
        i_cfg_wdata      = '0;
        cmds_sent        = 0;
        settings_applied = 0;
        sender_calm      = 1'b0;
        receiver_calm    = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: idle tick, spare opcode, angle limits, clamps, ramps, retarget
        send_cmd(OP_TICK, 0, 0);
        send_cmd(OP_SPARE, 262143, 1048575);
        send_cmd(OP_PLACE, 92160, 0);
        send_cmd(OP_PLACE, 131071, 0);
        send_cmd(OP_PLACE, -131072, 0);
        send_cmd(OP_PLACE, 0, 0);
        send_cmd(OP_SET, -5000, 0);
        send_cmd(OP_TICK, 0, 0);
        send_cmd(OP_TICK, 0, 0);
        send_cmd(OP_SET, 46080, 1048575);
        repeat (3) send_cmd(OP_TICK, 0, 0);
        send_cmd(OP_SET, 131071, 255999);
        send_cmd(OP_TICK, 0, 0);
        send_cmd(OP_PLACE, 45000, 0);
        send_cmd(OP_TICK, 0, 0);
        send_cmd(OP_SET, 20000, 1023999);
        repeat (4) send_cmd(OP_TICK, 0, 0);
        send_cmd(OP_SET, 46080, 999);
        send_cmd(OP_TICK, 0, 0);
        send_cmd(OP_PLACE, -46080, 0);

        run_random(350, 0);
        load_duty_setting(-46080, 1'b1, 0, 65535);
        run_random(350, 175);
        load_duty_setting(46080, 1'b0, 65535, 0);
        sender_calm   = 1'b1;
        receiver_calm = 1'b1;
        run_random(350, 0);
        sender_calm   = 1'b0;
        receiver_calm = 1'b0;
        load_duty_setting(0, 1'b0, 3000, 6000);
        run_random(350, 0);
        load_duty_setting(longint'($urandom_range(92160)) - 46080, 1'($urandom_range(1)),
                          longint'($urandom_range(65535)), longint'($urandom_range(65535)));
        run_random(350, 0);

        s_axis_tvalid <= 1'b0;
        wait (outstanding == 0);
        repeat (10) @(posedge i_clk);
        $display("Sent %0d commands across %0d duty register settings, %0d results checked",
                 cmds_sent, settings_applied + 1, checked);
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASS servo_slew_ramp_pwm_top");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, outstanding);
            $display("FAIL servo_slew_ramp_pwm_top");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/ssrp_pkg.sv
rtl/core/ssrp_duty.sv
rtl/core/ssrp_fifo.sv
rtl/core/servo_slew_ramp_pwm_top.sv
tb/servo_result_checker.sv
tb/servo_slew_ramp_pwm_top_tb.sv
